// File: hdl/rth_pkg.sv
// Shared types and constants for the RGB to HSL pixel converter.
// Depends on nothing; every other file of the converter imports it.
package rth_pkg;

    // Field widths
    localparam int CHAN_W  = 8;   // one colour channel
    localparam int HUE_W   = 13;  // hue in sixteenths of a degree
    localparam int QUO_W   = 10;  // quotient bits produced by the divider
    localparam int NUM_W   = CHAN_W + QUO_W;
    localparam int SUM_W   = CHAN_W + 1;

    // Stream data widths, rounded up to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int M_USED_W = HUE_W + 2 * CHAN_W;

    // Fixed-point constants
    localparam logic [CHAN_W-1:0] FULL_CODE   = 8'd255;
    localparam logic [SUM_W-1:0]  TWICE_FULL  = 9'd510;
    localparam logic [NUM_W-1:0]  HUE_SIXTY   = 18'd960;   // 60 degrees
    localparam logic [HUE_W-1:0]  HUE_GREEN   = 13'd1920;  // 120 degrees
    localparam logic [HUE_W-1:0]  HUE_BLUE    = 13'd3840;  // 240 degrees
    localparam logic [HUE_W-1:0]  HUE_FULL    = 13'd5760;  // 360 degrees
    localparam logic [HUE_W-1:0]  HUE_LIMIT   = 13'd5759;

    // Divider lanes
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANES    = 2;

    // Hue sector: which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } rth_sector_t;

    // Values that ride alongside the divider
    typedef struct packed {
        rth_sector_t        sector;
        logic               neg;      // channel difference is negative
        logic               grey;     // max equals min
        logic [CHAN_W-1:0]  light;
    } rth_side_t;

    localparam int SIDE_W = $bits(rth_side_t);

    // Channel extrema after the first front stage
    typedef struct packed {
        logic [CHAN_W-1:0]  delta;
        logic [SUM_W-1:0]   sum;
        rth_sector_t        sector;
        logic               neg;
        logic [CHAN_W-1:0]  absdiff;
    } rth_ext_t;

    // Dividends and divisors handed to the divider
    typedef struct packed {
        logic [NUM_W-1:0]   hue_num;
        logic [CHAN_W-1:0]  hue_den;
        logic [NUM_W-1:0]   sat_num;
        logic [CHAN_W-1:0]  sat_den;
        rth_side_t          side;
    } rth_div_in_t;

endpackage

// File: hdl/rth_front.sv
// Front end of the converter: channel extrema, sector, and the dividends.
// Two register stages with per-stage valid and ready. Uses rth_pkg.
module rth_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rth_pkg::CHAN_W-1:0]   in_red,
    input  logic [rth_pkg::CHAN_W-1:0]   in_green,
    input  logic [rth_pkg::CHAN_W-1:0]   in_blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rth_pkg::rth_div_in_t         out_data
);
    import rth_pkg::*;

    logic        ext_valid_reg;
    rth_ext_t    ext_reg;
    rth_ext_t    ext_next;
    logic        ext_ready;

    logic        div_valid_reg;
    rth_div_in_t div_reg;
    rth_div_in_t div_next;
    logic        div_ready;

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] opa;
    logic [CHAN_W-1:0] opb;

    // A stage takes a new transaction when empty or when its successor moves
    assign div_ready = !div_valid_reg || out_ready;
    assign ext_ready = !ext_valid_reg || div_ready;
    assign in_ready  = ext_ready;

    // Find max, min and the sector, then the signed channel difference
    always_comb begin
        mx = in_red;
        mn = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue  > mx) mx = in_blue;
        if (in_green < mn) mn = in_green;
        if (in_blue  < mn) mn = in_blue;

        priority if (in_red == mx) begin
            ext_next.sector = SEC_RED;
            opa = in_green;
            opb = in_blue;
        end else if (in_green == mx) begin
            ext_next.sector = SEC_GREEN;
            opa = in_blue;
            opb = in_red;
        end else begin
            ext_next.sector = SEC_BLUE;
            opa = in_red;
            opb = in_green;
        end

        ext_next.neg     = opa < opb;
        ext_next.absdiff = (opa < opb) ? (opb - opa) : (opa - opb);
        ext_next.delta   = mx - mn;
        ext_next.sum     = SUM_W'(mx) + SUM_W'(mn);
    end

    // Form the dividends, the divisors and the lightness
    always_comb begin
        div_next.hue_num = NUM_W'(ext_reg.absdiff) * HUE_SIXTY;
        div_next.hue_den = ext_reg.delta;
        div_next.sat_num = (NUM_W'(ext_reg.delta) << CHAN_W) - NUM_W'(ext_reg.delta);
        if (ext_reg.sum > SUM_W'(FULL_CODE)) begin
            div_next.sat_den = CHAN_W'(TWICE_FULL - ext_reg.sum);
        end else begin
            div_next.sat_den = ext_reg.sum[CHAN_W-1:0];
        end
        div_next.side.sector = ext_reg.sector;
        div_next.side.neg    = ext_reg.neg;
        div_next.side.grey   = (ext_reg.delta == '0);
        div_next.side.light  = CHAN_W'((SUM_W'(ext_reg.sum) + SUM_W'(1)) >> 1);
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end else begin
            if (ext_ready) ext_valid_reg <= in_valid;
            if (div_ready) div_valid_reg <= ext_valid_reg;
        end
    end

    // Load payload only with a live transaction
    always_ff @(posedge aclk) begin
        if (ext_ready && in_valid)      ext_reg <= ext_next;
        if (div_ready && ext_valid_reg) div_reg <= div_next;
    end

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

endmodule

// File: hdl/rth_divider.sv
// Pipelined restoring divider with several lanes in lockstep and a side band.
// Produces STEPS quotient bits per stage; the quotient must fit Q_BITS. Uses rth_pkg.
module rth_divider #(
    parameter int LANES  = 2,
    parameter int Q_BITS = 10,
    parameter int D_BITS = 8,
    parameter int STEPS  = 2,
    parameter int SB_W   = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [D_BITS+Q_BITS-1:0]   in_num [LANES],
    input  logic [D_BITS-1:0]          in_den [LANES],
    input  logic [SB_W-1:0]            in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [Q_BITS-1:0]          out_quo [LANES],
    output logic [SB_W-1:0]            out_side
);
    import rth_pkg::*;

    localparam int STAGES = (Q_BITS + STEPS - 1) / STEPS;

    // Stage registers
    logic              valid_reg [STAGES];
    logic [SB_W-1:0]   side_reg  [STAGES];
    logic [D_BITS-1:0] rem_reg   [STAGES][LANES];
    logic [Q_BITS-1:0] low_reg   [STAGES][LANES];
    logic [Q_BITS-1:0] quo_reg   [STAGES][LANES];
    logic [D_BITS-1:0] den_reg   [STAGES][LANES];

    // Stage inputs
    logic              valid_in  [STAGES];
    logic [SB_W-1:0]   side_in   [STAGES];
    logic [D_BITS-1:0] rem_in    [STAGES][LANES];
    logic [Q_BITS-1:0] low_in    [STAGES][LANES];
    logic [Q_BITS-1:0] quo_in    [STAGES][LANES];
    logic [D_BITS-1:0] den_in    [STAGES][LANES];

    logic              stage_ready [STAGES];

    assign in_ready = stage_ready[0];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        // Ready chain: take a transaction when empty or when the next stage moves
        if (s == STAGES - 1) begin : g_last
            assign stage_ready[s] = !valid_reg[s] || out_ready;
        end else begin : g_mid
            assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end

        // Select the stage input: fresh dividend or the previous stage
        if (s == 0) begin : g_first
            assign valid_in[s] = in_valid;
            assign side_in[s]  = in_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane_in
                assign rem_in[s][l] = in_num[l][D_BITS+Q_BITS-1:Q_BITS];
                assign low_in[s][l] = in_num[l][Q_BITS-1:0];
                assign quo_in[s][l] = '0;
                assign den_in[s][l] = in_den[l];
            end
        end else begin : g_next
            assign valid_in[s] = valid_reg[s-1];
            assign side_in[s]  = side_reg[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane_in
                assign rem_in[s][l] = rem_reg[s-1][l];
                assign low_in[s][l] = low_reg[s-1][l];
                assign quo_in[s][l] = quo_reg[s-1][l];
                assign den_in[s][l] = den_reg[s-1][l];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [D_BITS-1:0] rem_next;
            logic [Q_BITS-1:0] low_next;
            logic [Q_BITS-1:0] quo_next;
            logic [D_BITS:0]   trial;

            // Shift in one dividend bit per step, subtract where it fits
            always_comb begin
                rem_next = rem_in[s][l];
                low_next = low_in[s][l];
                quo_next = quo_in[s][l];
                trial    = '0;
                for (int j = 0; j < STEPS; j++) begin
                    if (s * STEPS + j < Q_BITS) begin
                        trial    = {rem_next, low_next[Q_BITS-1]};
                        low_next = {low_next[Q_BITS-2:0], 1'b0};
                        if (trial >= {1'b0, den_in[s][l]}) begin
                            rem_next = D_BITS'(trial - {1'b0, den_in[s][l]});
                            quo_next = {quo_next[Q_BITS-2:0], 1'b1};
                        end else begin
                            rem_next = trial[D_BITS-1:0];
                            quo_next = {quo_next[Q_BITS-2:0], 1'b0};
                        end
                    end
                end
            end

            // Hold the partial result with its transaction
            always_ff @(posedge aclk) begin
                if (stage_ready[s] && valid_in[s]) begin
                    rem_reg[s][l] <= rem_next;
                    low_reg[s][l] <= low_next;
                    quo_reg[s][l] <= quo_next;
                    den_reg[s][l] <= den_in[s][l];
                end
            end
        end

        // Advance the valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                valid_reg[s] <= valid_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[s] && valid_in[s]) side_reg[s] <= side_in[s];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_quo[l] = quo_reg[STAGES-1][l];
    end

endmodule

// File: hdl/rth_back.sv
// Output stage: places the hue quotient in its sector, masks grey pixels and
// registers the result transaction. Uses rth_pkg.
module rth_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rth_pkg::QUO_W-1:0]     in_hue_quo,
    input  logic [rth_pkg::QUO_W-1:0]     in_sat_quo,
    input  rth_pkg::rth_side_t            in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rth_pkg::HUE_W-1:0]     out_hue,
    output logic [rth_pkg::CHAN_W-1:0]    out_sat,
    output logic [rth_pkg::CHAN_W-1:0]    out_light
);
    import rth_pkg::*;

    logic              valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [CHAN_W-1:0] sat_reg;
    logic [CHAN_W-1:0] sat_next;
    logic [CHAN_W-1:0] light_reg;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  quo;

    // Take a transaction while the output is empty or being taken
    assign in_ready = !valid_reg || out_ready;

    // Offset the quotient by its sector; wrap a negative red hue by 360 degrees
    always_comb begin
        quo = HUE_W'(in_hue_quo);
        unique case (in_side.sector)
            SEC_RED:   base = (in_side.neg && quo != '0) ? HUE_FULL : '0;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = '0;
        endcase
        hue_next = in_side.neg ? (base - quo) : (base + quo);

        // Clip saturation at full scale
        if (in_sat_quo > QUO_W'(FULL_CODE)) begin
            sat_next = FULL_CODE;
        end else begin
            sat_next = in_sat_quo[CHAN_W-1:0];
        end

        // Grey pixel: no hue, no saturation
        if (in_side.grey) begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= in_side.light;
        end
    end

    assign out_valid = valid_reg;
    assign out_hue   = hue_reg;
    assign out_sat   = sat_reg;
    assign out_light = light_reg;

endmodule

// File: hdl/rgb_to_hsl_converter_unit.sv
// Top level of the RGB to HSL pixel converter.
// Joins rth_front, rth_divider and rth_back; uses rth_pkg.
//
//  channel | ports        | tdata fields (lowest bit first)
//  --------+--------------+-----------------------------------------------
//  input   | s_tvalid/... | red[7:0], green[15:8], blue[23:16]
//  result  | m_tvalid/... | hue[12:0], saturation[20:13], lightness[28:21], 0
//
// One pixel enters per clock while s_tready is high; each pixel passes through
// two front stages, five divider stages (two quotient bits per stage) and the
// output register. Every stage has its own valid bit and takes a new
// transaction when it is empty or its successor moves, so a stall on the result
// side fills bubbles before s_tready drops. Reset clears the valid bits only;
// the converter keeps no state between pixels.
module rgb_to_hsl_converter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rth_pkg::S_DATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rth_pkg::M_DATA_W-1:0]  m_tdata    // hue, saturation, lightness, zeros
);
    import rth_pkg::*;

    logic        div_in_valid;
    logic        div_in_ready;
    rth_div_in_t div_in;

    logic [NUM_W-1:0]  num  [LANES];
    logic [CHAN_W-1:0] den  [LANES];
    logic [QUO_W-1:0]  quo  [LANES];
    logic [SIDE_W-1:0] side_out;
    rth_side_t         side_res;

    logic        back_valid;
    logic        back_ready;

    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] light;

    // Extrema and dividends
    rth_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_red    (s_tdata[CHAN_W-1:0]),
        .in_green  (s_tdata[2*CHAN_W-1:CHAN_W]),
        .in_blue   (s_tdata[3*CHAN_W-1:2*CHAN_W]),
        .out_valid (div_in_valid),
        .out_ready (div_in_ready),
        .out_data  (div_in)
    );

    assign num[LANE_HUE] = div_in.hue_num;
    assign den[LANE_HUE] = div_in.hue_den;
    assign num[LANE_SAT] = div_in.sat_num;
    assign den[LANE_SAT] = div_in.sat_den;

    // Hue and saturation quotients in lockstep
    rth_divider #(
        .LANES  (LANES),
        .Q_BITS (QUO_W),
        .D_BITS (CHAN_W),
        .STEPS  (2),
        .SB_W   (SIDE_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_num    (num),
        .in_den    (den),
        .in_side   (div_in.side),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_quo   (quo),
        .out_side  (side_out)
    );

    assign side_res = rth_side_t'(side_out);

    // Sector offset, grey mask and result register
    rth_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (back_valid),
        .in_ready   (back_ready),
        .in_hue_quo (quo[LANE_HUE]),
        .in_sat_quo (quo[LANE_SAT]),
        .in_side    (side_res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hue    (hue),
        .out_sat    (sat),
        .out_light  (light)
    );

    assign m_tdata = {(M_DATA_W - M_USED_W)'(0), light, sat, hue};

endmodule

// File: hdl/rth_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level.
// Uses rth_pkg for field widths and limits.
module rth_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rth_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rth_pkg::M_DATA_W-1:0]  m_tdata
);
    import rth_pkg::*;

    logic [HUE_W-1:0]  hue_f;
    logic [CHAN_W-1:0] sat_f;

    assign hue_f = m_tdata[HUE_W-1:0];
    assign sat_f = m_tdata[HUE_W+CHAN_W-1:HUE_W];

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Hue stays below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hue_f <= HUE_LIMIT)
        else $error("hue out of range");

    // Zero saturation only for grey pixels, which carry no hue
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sat_f == '0 |-> hue_f == '0)
        else $error("grey pixel with nonzero hue");

    // Padding bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:M_USED_W] == '0)
        else $error("padding bits set");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb_to_hsl_converter_unit rth_checker u_rth_checker (.*);
